[hw/rtl/svc_pkg.sv]
// Shared types, widths and helpers for the sphere / view cone cull block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package svc_pkg;

  localparam int CoordW  = 32;   // Q24.8 coordinates
  localparam int RelW    = 33;   // centre minus camera
  localparam int RadW    = 31;
  localparam int DirW    = 16;
  localparam int ParW    = 16;
  localparam int SqW     = 2 * RelW;
  localparam int RadSqW  = 2 * RadW;
  localparam int ProdW   = RelW + DirW;
  localparam int DsqW    = SqW + 1;
  localparam int AlongW  = 51;
  localparam int MagW    = AlongW - 1;
  localparam int HalfW   = MagW / 2;
  localparam int PartW   = 2 * HalfW;
  localparam int AsqW    = 100;
  localparam int PsqW    = 94;
  localparam int RootW   = PsqW / 2;
  localparam int RemW    = RootW + 3;
  localparam int AtanW   = AlongW + ParW;
  localparam int DiffW   = AtanW + 1;
  localparam int DistW   = DiffW + ParW + 1;
  localparam int CfgIdxW = 4;
  localparam int CfgDatW = 32;

  localparam longint NearDist = 256;
  localparam longint NearLim  = NearDist * 16384;

  localparam logic [1:0] VIS_OUTSIDE = 2'd0;
  localparam logic [1:0] VIS_PARTIAL = 2'd1;
  localparam logic [1:0] VIS_INSIDE  = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CAM_X   = 4'd0,
    REG_CAM_Y   = 4'd1,
    REG_CAM_Z   = 4'd2,
    REG_VIEW_DX = 4'd3,
    REG_VIEW_DY = 4'd4,
    REG_VIEW_DZ = 4'd5,
    REG_CONE_TAN = 4'd6,
    REG_CONE_COS = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] cam_x;
    logic signed [CoordW-1:0] cam_y;
    logic signed [CoordW-1:0] cam_z;
    logic signed [DirW-1:0]   view_dx;
    logic signed [DirW-1:0]   view_dy;
    logic signed [DirW-1:0]   view_dz;
    logic [ParW-1:0]          cone_tangent;
    logic [ParW-1:0]          cone_cosine;
  } svc_cfg_t;

  // per-item data that rides alongside the root extraction
  typedef struct packed {
    logic                    in_sphere;
    logic                    near_out;
    logic [RadW-1:0]         rad;
    logic signed [AtanW-1:0] atan;
  } svc_side_t;

  typedef struct packed {
    logic [PsqW-1:0]  arg;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } svc_sqrt_t;

  // one restoring square root step: consumes the top two bits of arg
  function automatic svc_sqrt_t sqrt_step(svc_sqrt_t s);
    logic [RemW-1:0] cur;
    logic [RemW-1:0] trial;
    svc_sqrt_t       r;
    cur   = {s.rem[RemW-3:0], s.arg[PsqW-1:PsqW-2]};
    trial = {1'b0, s.root, 2'b01};
    r.arg = {s.arg[PsqW-3:0], 2'b00};
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {s.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/svc_cfg.sv]
// Configuration register file: camera, view direction and cone terms.
// Depends on svc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svc_cfg
  import svc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire logic [CfgIdxW-1:0] wr_index,
  input  wire logic [CfgDatW-1:0] wr_data,
  output svc_cfg_t                cfg
);

  svc_cfg_t cfg_r;
  svc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_CAM_X:    cfg_nxt.cam_x        = wr_data;
        REG_CAM_Y:    cfg_nxt.cam_y        = wr_data;
        REG_CAM_Z:    cfg_nxt.cam_z        = wr_data;
        REG_VIEW_DX:  cfg_nxt.view_dx      = wr_data[DirW-1:0];
        REG_VIEW_DY:  cfg_nxt.view_dy      = wr_data[DirW-1:0];
        REG_VIEW_DZ:  cfg_nxt.view_dz      = wr_data[DirW-1:0];
        REG_CONE_TAN: cfg_nxt.cone_tangent = wr_data[ParW-1:0];
        REG_CONE_COS: cfg_nxt.cone_cosine  = wr_data[ParW-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cam_x        <= '0;
      cfg_r.cam_y        <= '0;
      cfg_r.cam_z        <= '0;
      cfg_r.view_dx      <= 16'sd16384;
      cfg_r.view_dy      <= '0;
      cfg_r.view_dz      <= '0;
      cfg_r.cone_tangent <= 16'd256;
      cfg_r.cone_cosine  <= 16'd23170;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hw/rtl/svc_front.sv]
// Front pipeline: relative position, squares, dot product, early tests,
// and the root argument |r|^2 * 2^28 - along^2 (seven stages). Uses svc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svc_front
  import svc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_v,
  input  wire logic signed [CoordW-1:0] cx,
  input  wire logic signed [CoordW-1:0] cy,
  input  wire logic signed [CoordW-1:0] cz,
  input  wire logic [RadW-1:0]          rad,
  input  svc_cfg_t                      cfg,
  output logic                          out_v,
  output logic [PsqW-1:0]               psq,
  output svc_side_t                     side
);

  logic [7:1] v_r;

  // stage 1
  logic signed [RelW-1:0] rx_r, ry_r, rz_r;
  logic [RadW-1:0]        rad1_r;
  // stage 2
  logic [SqW-1:0]          sqx_r, sqy_r, sqz_r;
  logic [RadSqW-1:0]       radsq2_r;
  logic signed [ProdW-1:0] prx_r, pry_r, prz_r;
  logic [RadW-1:0]         rad2_r;
  // stage 3
  logic [DsqW-1:0]          dsq3_r;
  logic signed [AlongW-1:0] along3_r;
  logic [RadSqW-1:0]        radsq3_r;
  logic [RadW-1:0]          rad3_r;
  // stage 4
  logic [DsqW-1:0]          dsq4_r;
  logic signed [AlongW-1:0] along4_r;
  logic [MagW-1:0]          amag4_r;
  logic                     insph4_r;
  logic [RadW-1:0]          rad4_r;
  // stage 5
  logic [DsqW-1:0]  dsq5_r;
  logic [PartW-1:0] hh5_r, hl5_r, ll5_r;
  svc_side_t        side5_r;
  // stage 6
  logic [DsqW-1:0] dsq6_r;
  logic [AsqW-1:0] asq6_r;
  svc_side_t       side6_r;
  // stage 7
  logic [PsqW-1:0] psq7_r;
  svc_side_t       side7_r;

  logic signed [RelW-1:0]   rx_nxt, ry_nxt, rz_nxt;
  logic signed [SqW-1:0]    sqx_w, sqy_w, sqz_w;
  logic signed [ProdW-1:0]  prx_w, pry_w, prz_w;
  logic [RadSqW-1:0]        radsq_w;
  logic [DsqW-1:0]          dsq_nxt;
  logic signed [AlongW-1:0] along_nxt;
  logic signed [AlongW:0]   near_sum;
  logic signed [AlongW-1:0] amag_w;
  logic [HalfW-1:0]         ahi, alo;
  logic signed [AtanW-1:0]  atan_w;
  logic [AsqW-1:0]          asq_nxt;
  logic [AsqW:0]            pdiff;
  logic [PsqW-1:0]          psq_nxt;

  always_comb begin
    rx_nxt = $signed({cx[CoordW-1], cx}) - $signed({cfg.cam_x[CoordW-1], cfg.cam_x});
    ry_nxt = $signed({cy[CoordW-1], cy}) - $signed({cfg.cam_y[CoordW-1], cfg.cam_y});
    rz_nxt = $signed({cz[CoordW-1], cz}) - $signed({cfg.cam_z[CoordW-1], cfg.cam_z});
    sqx_w   = rx_r * rx_r;
    sqy_w   = ry_r * ry_r;
    sqz_w   = rz_r * rz_r;
    prx_w   = rx_r * cfg.view_dx;
    pry_w   = ry_r * cfg.view_dy;
    prz_w   = rz_r * cfg.view_dz;
    radsq_w = rad1_r * rad1_r;
    dsq_nxt   = {1'b0, sqx_r} + {1'b0, sqy_r} + {1'b0, sqz_r};
    along_nxt = prx_r + pry_r + prz_r;
    near_sum  = along4_r + $signed({7'b0, rad4_r, 14'b0});
    amag_w    = along3_r[AlongW-1] ? -along3_r : along3_r;
    ahi       = amag4_r[MagW-1:HalfW];
    alo       = amag4_r[HalfW-1:0];
    atan_w    = along4_r * $signed({1'b0, cfg.cone_tangent});
    asq_nxt   = (AsqW'(hh5_r) << (2 * HalfW)) + (AsqW'(hl5_r) << (HalfW + 1))
              + AsqW'(ll5_r);
    pdiff     = (AsqW+1)'({dsq6_r, 28'b0}) - {1'b0, asq6_r};
    // a negative argument from rounding clamps to zero
    psq_nxt   = pdiff[AsqW] ? '0 : pdiff[PsqW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:1], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      rz_r   <= rz_nxt;
      rad1_r <= rad;

      sqx_r    <= sqx_w;
      sqy_r    <= sqy_w;
      sqz_r    <= sqz_w;
      prx_r    <= prx_w;
      pry_r    <= pry_w;
      prz_r    <= prz_w;
      radsq2_r <= radsq_w;
      rad2_r   <= rad1_r;

      dsq3_r   <= dsq_nxt;
      along3_r <= along_nxt;
      radsq3_r <= radsq2_r;
      rad3_r   <= rad2_r;

      dsq4_r   <= dsq3_r;
      along4_r <= along3_r;
      amag4_r  <= amag_w[MagW-1:0];
      insph4_r <= dsq3_r <= DsqW'(radsq3_r);
      rad4_r   <= rad3_r;

      dsq5_r            <= dsq4_r;
      hh5_r             <= ahi * ahi;
      hl5_r             <= ahi * alo;
      ll5_r             <= alo * alo;
      side5_r.in_sphere <= insph4_r;
      side5_r.near_out  <= near_sum <= (AlongW+1)'(NearLim);
      side5_r.rad       <= rad4_r;
      side5_r.atan      <= atan_w;

      dsq6_r  <= dsq5_r;
      asq6_r  <= asq_nxt;
      side6_r <= side5_r;

      psq7_r  <= psq_nxt;
      side7_r <= side6_r;
    end
  end

  assign out_v = v_r[7];
  assign psq   = psq7_r;
  assign side  = side7_r;

endmodule

`default_nettype wire

[hw/rtl/svc_sqrt.sv]
// Pipelined restoring square root, one result bit per stage, with the
// item's side data carried alongside. Uses svc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svc_sqrt
  import svc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_v,
  input  wire logic [PsqW-1:0]  arg,
  input  svc_side_t             in_side,
  output logic                  out_v,
  output logic [RootW-1:0]      root,
  output svc_side_t             out_side
);

  logic [RootW-1:0] v_r;
  svc_sqrt_t        st_r   [RootW];
  svc_side_t        side_r [RootW];
  svc_sqrt_t        st0;

  assign st0 = '{arg: arg, rem: '0, root: '0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[RootW-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]   <= sqrt_step(st0);
      side_r[0] <= in_side;
    end
  end

  for (genvar i = 1; i < RootW; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i]   <= sqrt_step(st_r[i-1]);
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_v    = v_r[RootW-1];
  assign root     = st_r[RootW-1].root;
  assign out_side = side_r[RootW-1];

endmodule

`default_nettype wire

[hw/rtl/svc_back.sv]
// Back pipeline: cone distance (perp - along * tan) * cos, compare with
// the radius, final visibility register. Uses svc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svc_back
  import svc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_v,
  input  wire logic [RootW-1:0]  perp,
  input  svc_side_t              side,
  input  wire logic [ParW-1:0]   cone_cosine,
  output logic                   out_v,
  output logic [1:0]             vis
);

  logic                    b1_v_r, b2_v_r, out_v_r;
  logic signed [DiffW-1:0] diff1_r;
  logic                    insph1_r, near1_r, insph2_r, near2_r;
  logic [RadW-1:0]         rad1_r;
  logic signed [DistW-1:0] dist2_r, rlim2_r;
  logic [1:0]              vis_r, vis_nxt;

  logic signed [DiffW-1:0] diff_nxt;
  logic signed [DistW-1:0] dist_nxt;

  always_comb begin
    diff_nxt = $signed({1'b0, (DiffW-1)'({perp, 8'b0})}) - side.atan;
    dist_nxt = diff1_r * $signed({1'b0, cone_cosine});
    if (insph2_r) begin
      vis_nxt = VIS_PARTIAL;
    end else if (near2_r) begin
      vis_nxt = VIS_OUTSIDE;
    end else if (rlim2_r <= dist2_r) begin
      vis_nxt = VIS_OUTSIDE;
    end else if (dist2_r <= -rlim2_r) begin
      vis_nxt = VIS_INSIDE;
    end else begin
      vis_nxt = VIS_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r  <= in_v;
      b2_v_r  <= b1_v_r;
      out_v_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff1_r  <= diff_nxt;
      insph1_r <= side.in_sphere;
      near1_r  <= side.near_out;
      rad1_r   <= side.rad;
      dist2_r  <= dist_nxt;
      rlim2_r  <= $signed(DistW'({rad1_r, 37'b0}));
      insph2_r <= insph1_r;
      near2_r  <= near1_r;
      vis_r    <= vis_nxt;
    end
  end

  assign out_v = out_v_r;
  assign vis   = vis_r;

  a_insph_partial: assert property (@(posedge clk) disable iff (!rst_n)
    en && b2_v_r && insph2_r |=> vis_r == VIS_PARTIAL)
    else $error("sphere around camera not partial");

  a_near_outside: assert property (@(posedge clk) disable iff (!rst_n)
    en && b2_v_r && !insph2_r && near2_r |=> vis_r == VIS_OUTSIDE)
    else $error("sphere behind near plane not outside");

  a_pos_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
    en && b2_v_r && !insph2_r && !near2_r && !dist2_r[DistW-1]
      |=> vis_r != VIS_INSIDE)
    else $error("non-negative cone distance classed inside");

endmodule

`default_nettype wire

[hw/rtl/sphere_view_cone_cull_top.sv]
// Sphere / view cone cull, top level: config registers and pipeline.
// Depends on svc_pkg, svc_cfg, svc_front, svc_sqrt, svc_back.
//
// Usage: one bounding sphere (centre, radius) per request on the in_
// channel, one visibility code per request on the out_ channel, in order
// (0 outside, 1 partial, 2 inside). A request is taken when valid is high
// and stall is low.
// Throughput: one sphere per cycle while not stalled. Path from acceptance
// to out_valid: seven front stages, 47 square root stages (one result
// bit each), and three back stages ending in the output register.
// Stall: the pipeline advances as one; while out_valid is high and
// out_stall is high every stage holds and in_stall is raised. Empty
// slots hold too, so a stalled result blocks input even with bubbles.
// Config: write cfg_index / cfg_data with cfg_valid; cfg_ready is always
// high. Write only while no request is in flight. Indexes above 7 are
// ignored.
// Reset (rst_n low, synchronous): pipeline empties, registers return to
// camera at origin, direction +x, tan 1.0, cos 0.7071.
`timescale 1ns / 1ps
`default_nettype none

module sphere_view_cone_cull_top
  import svc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CoordW-1:0] in_centre_x,
  input  wire logic [CoordW-1:0] in_centre_y,
  input  wire logic [CoordW-1:0] in_centre_z,
  input  wire logic [RadW-1:0]   in_radius,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_visibility,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgDatW-1:0] cfg_data
);

  svc_cfg_t         cfg;
  logic             en;
  logic             fr_v, sq_v;
  logic [PsqW-1:0]  fr_psq;
  svc_side_t        fr_side, sq_side;
  logic [RootW-1:0] sq_root;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  svc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  svc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_valid),
    .cx    ($signed(in_centre_x)),
    .cy    ($signed(in_centre_y)),
    .cz    ($signed(in_centre_z)),
    .rad   (in_radius),
    .cfg   (cfg),
    .out_v (fr_v),
    .psq   (fr_psq),
    .side  (fr_side)
  );

  svc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (fr_v),
    .arg      (fr_psq),
    .in_side  (fr_side),
    .out_v    (sq_v),
    .root     (sq_root),
    .out_side (sq_side)
  );

  svc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_v        (sq_v),
    .perp        (sq_root),
    .side        (sq_side),
    .cone_cosine (cfg.cone_cosine),
    .out_v       (out_valid),
    .vis         (out_visibility)
  );

endmodule

`default_nettype wire
